>>> hw/rtl/mrd_pkg.sv
// Shared types and constants of the multichannel ramped dimmer.
// No dependencies; every other file imports it.
package mrd_pkg;

	localparam int CH_FIELD_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [2:0] ACT_SET_LEVEL = 3'd0;
	localparam logic [2:0] ACT_ON_OFF    = 3'd1;
	localparam logic [2:0] ACT_DELAY     = 3'd2;
	localparam logic [2:0] ACT_MIN       = 3'd3;
	localparam logic [2:0] ACT_MAX       = 3'd4;
	localparam logic [2:0] ACT_RAMP      = 3'd5;
	localparam logic [2:0] ACT_TICK      = 3'd6;
	localparam logic [2:0] ACT_UNUSED    = 3'd7;

	localparam logic [6:0]  FULL_LEVEL  = 7'd100;
	localparam logic [7:0]  MAX_SECONDS = 8'd127;
	localparam logic [10:0] ELAPSED_MAX = 11'd2047;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] sensor_id;
		logic [7:0] value;
	} in_item_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0] out_channel;
		logic [6:0]            drive_value;
		logic                  last_change;
	} out_item_t;

	// classified item as queued between front and back
	typedef struct packed {
		logic                  is_tick;
		logic [2:0]            action;
		logic [CH_FIELD_W-1:0] ch;
		logic [7:0]            value;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic                  walking;
		logic [CH_FIELD_W-1:0] idx;
	} back_status_t;

	function automatic logic [10:0] elapsed_inc(input logic [10:0] e);
		return (e == ELAPSED_MAX) ? e : e + 11'd1;
	endfunction

	// channel changes on this tick, given its already incremented elapsed count
	function automatic logic level_changes(input logic [6:0] cur, input logic [6:0] tgt,
			input logic [10:0] ela_nx, input logic [10:0] dly, input logic ramp);
		return (cur != tgt) && (!ramp || (ela_nx >= dly));
	endfunction

	function automatic logic [6:0] sat100(input logic [7:0] v);
		return (v > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : v[6:0];
	endfunction

endpackage

>>> hw/rtl/mrd_front.sv
// Front end: holds first_sensor_id, accepts items, drops out-of-range commands and action 7.
// Depends on mrd_pkg.
module mrd_front #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  mrd_pkg::in_item_t item,
	input  mrd_pkg::q_status_t q_st,
	output logic              push,
	output mrd_pkg::q_entry_t push_entry
);
	import mrd_pkg::*;

	logic [7:0] first_q;
	logic [7:0] diff;
	logic       is_tick;
	logic       cmd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			first_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	always_comb begin
		diff    = item.sensor_id - first_q;
		is_tick = (item.action == ACT_TICK);
		cmd_ok  = (item.action inside {ACT_SET_LEVEL, ACT_ON_OFF, ACT_DELAY,
				ACT_MIN, ACT_MAX, ACT_RAMP})
			&& (item.sensor_id >= first_q) && (diff < 8'(NUM_CHANNELS));
	end

	assign item_ready = !q_st.full;
	assign push = item_valid && item_ready && (is_tick || cmd_ok);

	always_comb begin
		push_entry.is_tick = is_tick;
		push_entry.action  = item.action;
		push_entry.ch      = diff[CH_FIELD_W-1:0];
		push_entry.value   = item.value;
	end

endmodule

>>> hw/rtl/mrd_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on mrd_pkg.
module mrd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mrd_pkg::q_entry_t  push_entry,
	input  logic               pop,
	output mrd_pkg::q_entry_t  head,
	output mrd_pkg::q_status_t st
);
	import mrd_pkg::*;

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign st.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign do_push  = push && !st.full;
	assign do_pop   = pop && !st.empty;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

>>> hw/rtl/mrd_back.sv
// Back end: channel state, command execution, tick walk, result register.
// Depends on mrd_pkg.
module mrd_back #(
	parameter int NUM_CHANNELS    = 4,
	parameter int DEFAULT_STEP_MS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrd_pkg::q_entry_t     head,
	input  mrd_pkg::q_status_t    q_st,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_ready,
	output mrd_pkg::out_item_t    result,
	output mrd_pkg::back_status_t st
);
	import mrd_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic [6:0]  tgt_q  [NUM_CHANNELS];
	logic [6:0]  cur_q  [NUM_CHANNELS];
	logic [10:0] dly_q  [NUM_CHANNELS];
	logic [10:0] ela_q  [NUM_CHANNELS];
	logic [6:0]  min_q  [NUM_CHANNELS];
	logic [6:0]  max_q  [NUM_CHANNELS];
	logic        ramp_q [NUM_CHANNELS];

	logic                    state_q;
	logic [CH_W-1:0]         idx_q;
	logic [NUM_CHANNELS-1:0] mask_q;
	logic                    res_valid_q;
	out_item_t               res_q;

	logic                    walking;
	logic [CH_W-1:0]         sel;
	logic [NUM_CHANNELS-1:0] mask_all;
	logic                    out_free;
	logic                    step_go;
	logic                    emit;
	logic                    last;
	logic                    walk_end;
	logic                    do_cmd;
	logic                    do_tick;
	logic [6:0]              cur_s;
	logic [6:0]              tgt_s;
	logic [10:0]             ela_nx;
	logic [6:0]              cur_nx;
	logic [7:0]              lvl_in;
	logic [6:0]              tgt_nx;
	logic [6:0]              secs;
	logic [10:0]             dly_nx;

	assign walking  = (state_q == ST_WALK);
	assign sel      = walking ? idx_q : head.ch[CH_W-1:0];
	assign pop      = !walking && !q_st.empty;
	assign do_cmd   = pop && !head.is_tick;
	assign do_tick  = pop && head.is_tick;
	assign out_free = !res_valid_q || result_ready;
	assign step_go  = walking && (!mask_q[idx_q] || out_free);
	assign emit     = step_go && mask_q[idx_q];
	assign walk_end = (idx_q == CH_W'(NUM_CHANNELS - 1));

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			mask_all[c] = level_changes(cur_q[c], tgt_q[c], elapsed_inc(ela_q[c]),
				dly_q[c], ramp_q[c]);
		end
	end

	// last result of a tick: no later channel in the walk changes
	always_comb begin
		last = 1'b1;
		for (int j = 0; j < NUM_CHANNELS; j++) begin
			if (j > int'(idx_q) && mask_q[j]) last = 1'b0;
		end
	end

	always_comb begin
		cur_s  = cur_q[sel];
		tgt_s  = tgt_q[sel];
		ela_nx = elapsed_inc(ela_q[sel]);
		if (!ramp_q[sel])        cur_nx = tgt_s;
		else if (tgt_s > cur_s)  cur_nx = cur_s + 7'd1;
		else                     cur_nx = cur_s - 7'd1;

		lvl_in = (head.action == ACT_ON_OFF)
			? ((head.value != 8'd0) ? {1'b0, FULL_LEVEL} : 8'd0) : head.value;
		if (lvl_in < {1'b0, min_q[sel]})      tgt_nx = min_q[sel];
		else if (lvl_in > {1'b0, max_q[sel]}) tgt_nx = max_q[sel];
		else                                  tgt_nx = lvl_in[6:0];

		secs   = (head.value > MAX_SECONDS) ? MAX_SECONDS[6:0] : head.value[6:0];
		dly_nx = ({4'd0, secs} << 3) + ({4'd0, secs} << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				tgt_q[c]  <= FULL_LEVEL;
				cur_q[c]  <= FULL_LEVEL;
				dly_q[c]  <= 11'(DEFAULT_STEP_MS);
				ela_q[c]  <= 11'd0;
				min_q[c]  <= 7'd0;
				max_q[c]  <= FULL_LEVEL;
				ramp_q[c] <= 1'b1;
			end
		end else if (do_cmd) begin
			case (head.action)
				ACT_SET_LEVEL, ACT_ON_OFF: tgt_q[sel] <= tgt_nx;
				ACT_DELAY: dly_q[sel] <= dly_nx;
				ACT_MIN:   min_q[sel] <= sat100(head.value);
				ACT_MAX:   max_q[sel] <= sat100(head.value);
				ACT_RAMP:  ramp_q[sel] <= (head.value != 8'd0);
				default: ;
			endcase
		end else if (step_go) begin
			if (mask_q[idx_q]) begin
				cur_q[sel] <= cur_nx;
				ela_q[sel] <= ramp_q[sel] ? 11'd0 : ela_nx;
			end else begin
				ela_q[sel] <= ela_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mask_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_tick) begin
						mask_q  <= mask_all;
						idx_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (step_go) begin
						if (walk_end) state_q <= ST_IDLE;
						else          idx_q <= idx_q + CH_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit)              res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_channel <= CH_FIELD_W'(idx_q);
			res_q.drive_value <= FULL_LEVEL - cur_nx;
			res_q.last_change <= last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign st.walking   = walking;
	assign st.idx       = CH_FIELD_W'(idx_q);

endmodule

>>> hw/rtl/multichannel_ramped_dimmer_unit.sv
// Top level of the multichannel ramped dimmer: front, queue and back.
// Depends on mrd_pkg, mrd_front, mrd_queue, mrd_back.
//
// Channels:
//   item   (valid/ready) one beat per command or tick: action, sensor_id, value.
//   result (valid/ready) one beat per channel whose level changed on a tick:
//          out_channel, drive_value (100 minus level), last_change on the
//          final beat of that tick.
//   cfg    (valid/ready) writes first_sensor_id; always ready. Write only
//          while idle.
// The front classifies each beat and drops out-of-range commands and action 7;
// kept beats enter a two-entry queue, so the front keeps accepting while the
// back is busy or stalled until that queue is full.
// A command is executed as it is dequeued. A tick is dequeued, then walks the
// channels one per cycle through the single channel-state port while the
// result register is free; no new item is dequeued until the walk ends.
// A tick's results pass the queue, the walk state and the result register.
// If the receiver stalls, the walk holds at the next changing channel until
// the result register frees; unchanged channels still advance.
// Reset: all channels at level 100, target 100, min 0, max 100, ramping on,
// delay DEFAULT_STEP_MS, elapsed 0; first_sensor_id 0; queue empty.
module multichannel_ramped_dimmer_unit #(
	parameter int NUM_CHANNELS    = 4,
	parameter int DEFAULT_STEP_MS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  mrd_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output mrd_pkg::out_item_t result
);
	import mrd_pkg::*;

	q_status_t    q_st;
	q_entry_t     push_entry;
	q_entry_t     head;
	logic         push;
	logic         pop;
	back_status_t back_st;

	mrd_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_st       (q_st),
		.push       (push),
		.push_entry (push_entry)
	);

	mrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.st         (q_st)
	);

	mrd_back #(
		.NUM_CHANNELS    (NUM_CHANNELS),
		.DEFAULT_STEP_MS (DEFAULT_STEP_MS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_st         (q_st),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.st           (back_st)
	);

	// results come only from a tick walk
	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!back_st.walking && (!result_valid || result_ready)) |=> !result_valid)
		else $error("result beat without a tick walk");

	a_walk_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.walking |-> (int'(back_st.idx) < NUM_CHANNELS))
		else $error("walk index beyond channel count");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.drive_value <= FULL_LEVEL)
			&& (int'(result.out_channel) < NUM_CHANNELS))
		else $error("result payload out of range");

	// the back never dequeues while walking a tick
	a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.walking |-> !pop)
		else $error("dequeue during tick walk");

endmodule

>>> tb/multichannel_ramped_dimmer_unit_tb.sv
// Self-checking bench for multichannel_ramped_dimmer_unit: directed, soak and random phases.
// A scoreboard class predicts drive beats per tick; depends on mrd_pkg and the RTL top level.
module multichannel_ramped_dimmer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrd_pkg::*;

	localparam int DRAIN_CYCLES = 16;      // walk of a tick plus queue and result register
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 56;
	localparam int SOAK_TICKS   = 12;

	// Predicts the drive beats of the dimmer and holds them until they arrive.
	class drive_scoreboard;
		localparam int NCH = 4;

		logic [7:0]  first_id;
		logic [6:0]  tgt[NCH];
		logic [6:0]  cur[NCH];
		logic [6:0]  lo[NCH];
		logic [6:0]  hi[NCH];
		logic [10:0] dly[NCH];
		logic [10:0] ela[NCH];
		logic        ramp[NCH];
		out_item_t   expected_drives[$];
		int          errors;

		function new();
			first_id = 8'd0;
			errors = 0;
			for (int c = 0; c < NCH; c++) begin
				tgt[c] = 7'd100;
				cur[c] = 7'd100;
				lo[c] = 7'd0;
				hi[c] = 7'd100;
				dly[c] = 11'd10;
				ela[c] = 11'd0;
				ramp[c] = 1'b1;
			end
		endfunction

		function logic [6:0] cap_level(logic [7:0] v);
			return (v > 8'd100) ? 7'd100 : v[6:0];
		endfunction

		// min is tested before max, so a min above max wins
		function void clamp_target(int c, logic [7:0] v);
			logic [6:0] lvl;
			lvl = cap_level(v);
			if (v < {1'b0, lo[c]})
				lvl = lo[c];
			else if (v > {1'b0, hi[c]})
				lvl = hi[c];
			tgt[c] = lvl;
		endfunction

		function void walk_channels();
			out_item_t batch[$];
			out_item_t beat;
			logic      moved;
			for (int c = 0; c < NCH; c++) begin
				moved = 1'b0;
				if (ela[c] != ELAPSED_MAX)
					ela[c] = ela[c] + 11'd1;
				if (cur[c] != tgt[c]) begin
					if (!ramp[c]) begin
						cur[c] = tgt[c];
						moved = 1'b1;
					end else if (ela[c] >= dly[c]) begin
						cur[c] = (tgt[c] > cur[c]) ? cur[c] + 7'd1 : cur[c] - 7'd1;
						ela[c] = 11'd0;
						moved = 1'b1;
					end
				end
				if (moved) begin
					beat.out_channel = 4'(c);
					beat.drive_value = FULL_LEVEL - cur[c];
					beat.last_change = 1'b0;
					batch.push_back(beat);
				end
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last_change = 1'b1;
			foreach (batch[i])
				expected_drives.push_back(batch[i]);
		endfunction

		// called for every accepted item beat
		function void apply_item(in_item_t it);
			logic [8:0] off;
			logic [7:0] secs;
			int         c;
			if (it.action == ACT_TICK) begin
				walk_channels();
				return;
			end
			if (it.action == ACT_UNUSED || it.sensor_id < first_id)
				return;
			off = {1'b0, it.sensor_id} - {1'b0, first_id};
			if (off >= 9'(NCH))
				return;
			c = int'(off);
			case (it.action)
				ACT_SET_LEVEL: clamp_target(c, it.value);
				ACT_ON_OFF:    clamp_target(c, (it.value != 8'd0) ? 8'd100 : 8'd0);
				ACT_DELAY: begin
					secs = (it.value > MAX_SECONDS) ? MAX_SECONDS : it.value;
					dly[c] = {3'b000, secs} * 11'd10;
				end
				ACT_MIN:  lo[c] = cap_level(it.value);
				ACT_MAX:  hi[c] = cap_level(it.value);
				default:  ramp[c] = (it.value != 8'd0);
			endcase
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// called for every accepted result beat
		function void check_drive(out_item_t got);
			out_item_t want;
			if (expected_drives.size() == 0) begin
				note_error($sformatf("unexpected drive beat: ch %0d drive %0d last %0b",
					got.out_channel, got.drive_value, got.last_change));
				return;
			end
			want = expected_drives.pop_front();
			if (got.out_channel !== want.out_channel || got.drive_value !== want.drive_value ||
					got.last_change !== want.last_change)
				note_error({$sformatf("drive mismatch: ch exp %0d got %0d, ",
					want.out_channel, got.out_channel),
					$sformatf("drive exp %0d got %0d, last exp %0b got %0b",
					want.drive_value, got.drive_value,
					want.last_change, got.last_change)});
		endfunction

		function int waiting();
			return expected_drives.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'd0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	in_item_t   item = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_item_t  result;

	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int cycles = 0;

	drive_scoreboard sb;

	multichannel_ramped_dimmer_unit #(
		.NUM_CHANNELS(4),
		.DEFAULT_STEP_MS(10)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: check accepted beats, stall in short bursts or one long hold
	initial begin : drive_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				sb.check_drive(result);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 5);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// valid stays high between back-to-back beats; this task only drops it for an idle burst
	task automatic send_item(input in_item_t it);
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.apply_item(it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [2:0] act, input logic [7:0] sid, input logic [7:0] val);
		in_item_t it;
		it.action = act;
		it.sensor_id = sid;
		it.value = val;
		send_item(it);
	endtask

	// stop offering, wait for every predicted beat, then let the walk finish
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_first_id(input logic [7:0] id);
		settle();
		cfg_data <= id;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.first_id = id;
		@(posedge clk);
	endtask

	// mostly in-range commands and ticks, some stray ids and unused actions
	function automatic in_item_t rand_item(input logic [7:0] base);
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		it.sensor_id = 8'($urandom_range(0, 255));
		it.value = 8'($urandom_range(0, 255));
		if (r < 40) begin
			it.action = ACT_TICK;
		end else if (r < 85) begin
			it.action = 3'($urandom_range(0, 5));
			it.sensor_id = base + 8'($urandom_range(0, 3));
			case (it.action)
				ACT_SET_LEVEL:
					if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, 100));
				ACT_ON_OFF:
					if ($urandom_range(0, 1) == 0) it.value = 8'd0;
				ACT_DELAY:
					if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, 1));
				ACT_MIN:
					if ($urandom_range(0, 2) != 0) it.value = 8'($urandom_range(0, 30));
				ACT_MAX:
					if ($urandom_range(0, 2) != 0) it.value = 8'($urandom_range(70, 100));
				default:
					if ($urandom_range(0, 1) == 0) it.value = 8'd0;
			endcase
		end else if (r < 95) begin
			it.action = 3'($urandom_range(0, 5));
		end else begin
			it.action = ACT_UNUSED;
		end
		return it;
	endfunction

	initial begin : stimulus
		logic [7:0] phase_ids[5];
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ids from zero
		send_fields(ACT_TICK, 8'hFF, 8'hFF);       // tick ignores id and value, nothing moves
		send_fields(ACT_UNUSED, 8'h00, 8'h55);     // unused action
		send_fields(ACT_SET_LEVEL, 8'd1, 8'hFF);   // clamps to max
		send_fields(ACT_SET_LEVEL, 8'd0, 8'd0);
		send_fields(ACT_RAMP, 8'd2, 8'd0);         // ramping off: jump
		send_fields(ACT_ON_OFF, 8'd2, 8'd0);
		send_fields(ACT_TICK, 8'h55, 8'hAA);
		send_fields(ACT_DELAY, 8'd0, 8'd0);        // zero delay steps every tick
		send_fields(ACT_TICK, 8'h00, 8'h00);
		send_fields(ACT_MIN, 8'd3, 8'hC8);         // limits saturate at 100
		send_fields(ACT_MAX, 8'd3, 8'd0);
		send_fields(ACT_SET_LEVEL, 8'd3, 8'd50);   // min above max gives min
		send_fields(ACT_ON_OFF, 8'd3, 8'd0);
		send_fields(ACT_DELAY, 8'd1, 8'hFF);       // seconds saturate at 127
		send_fields(ACT_MAX, 8'd1, 8'd40);
		send_fields(ACT_SET_LEVEL, 8'd1, 8'h80);
		send_fields(ACT_SET_LEVEL, 8'd4, 8'd0);    // above the channel range
		send_fields(ACT_RAMP, 8'd2, 8'h80);
		send_fields(ACT_ON_OFF, 8'd2, 8'h01);
		send_fields(ACT_DELAY, 8'd2, 8'd1);
		repeat (4) send_fields(ACT_TICK, 8'h00, 8'h00);

		write_first_id(8'hFF);
		send_fields(ACT_SET_LEVEL, 8'hFF, 8'd30);
		send_fields(ACT_SET_LEVEL, 8'hFE, 8'd0);   // below first id
		send_fields(ACT_TICK, 8'h00, 8'h00);

		// soak: settle all channels, then a run of ticks with ramping on
		write_first_id(8'h00);
		for (int c = 0; c < 4; c++)
			send_fields(ACT_RAMP, 8'(c), 8'd0);
		repeat (2) send_fields(ACT_TICK, 8'h00, 8'h00);
		for (int c = 0; c < 4; c++)
			send_fields(ACT_RAMP, 8'(c), 8'd1);
		for (int i = 0; i < SOAK_TICKS; i++)
			send_fields(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		send_fields(ACT_DELAY, 8'd0, 8'd127);
		send_fields(ACT_SET_LEVEL, 8'd0, 8'd0);
		send_fields(ACT_TICK, 8'h00, 8'h00);       // long delay holds the step back

		phase_ids[0] = 8'h00;
		phase_ids[1] = 8'd252;
		phase_ids[2] = 8'hFF;
		phase_ids[3] = 8'($urandom_range(1, 251));
		phase_ids[4] = 8'h00;
		for (int p = 0; p < 5; p++) begin
			if (p == 4)
				idle_on = 1'b0;
			write_first_id(phase_ids[p]);
			if (p == 0) begin
				// jumps on all channels while the receiver holds off: the block backs up
				for (int c = 0; c < 4; c++) begin
					send_fields(ACT_MIN, 8'(c), 8'd0);
					send_fields(ACT_MAX, 8'(c), 8'd100);
					send_fields(ACT_RAMP, 8'(c), 8'd0);
				end
				long_hold_req = 1'b1;
				for (int k = 0; k < 8; k++) begin
					for (int c = 0; c < 4; c++)
						send_fields(ACT_ON_OFF, 8'(c), 8'(k % 2));
					send_fields(ACT_TICK, 8'h00, 8'h00);
				end
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(rand_item(phase_ids[p]));
		end

		settle();
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
